@@ rtl/wwks_pkg.sv @@
// Shared types and constants for the wedge weighted k-point sum block.
package wwks_pkg;

  localparam int ACC_W      = 56;
  localparam int FREQ_W     = 16;
  localparam int FCOUNT_W   = 17;
  localparam int SIDE_REG_W = 9;
  localparam int RECIP_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_RECIPROCAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_COUNT     = 2'd2;

  localparam logic [SIDE_REG_W-1:0] GRID_SIDE_RST      = 9'd2;
  localparam logic [RECIP_W-1:0]    NORM_RECIPROCAL_RST = 32'h4000_0000;
  localparam logic [FCOUNT_W-1:0]   FREQ_COUNT_RST     = 17'd1;

  // Largest frequency count that has any effect.
  localparam logic [FCOUNT_W-1:0]   FREQ_COUNT_MAX     = 17'h1_0000;

  typedef struct packed {
    logic [SIDE_REG_W-1:0] grid_side;
    logic [RECIP_W-1:0]    norm_reciprocal;
    logic [FCOUNT_W-1:0]   freq_count;
  } wwks_cfg_t;

  // Completed row sums handed from the accumulator to the scaling pipeline.
  typedef struct packed {
    logic              valid;
    logic [ACC_W-1:0]  sum_re;
    logic [ACC_W-1:0]  sum_im;
    logic [FREQ_W-1:0] freq_index;
    logic              last;
  } wwks_row_t;

endpackage

@@ rtl/wwks_if.sv @@
// Stream interfaces for the sample input and the mean output channels.
interface wwks_in_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_re;
  logic signed [SAMPLE_BITS-1:0] sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface wwks_out_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                                 valid;
  logic                                 ready;
  logic signed [SAMPLE_BITS-1:0]        mean_re;
  logic signed [SAMPLE_BITS-1:0]        mean_im;
  logic [wwks_pkg::FREQ_W-1:0]          freq_index;
  logic                                 last_freq;
  logic                                 saturated;

  modport source (output valid, output mean_re, output mean_im, output freq_index,
                  output last_freq, output saturated, input ready);
  modport sink   (input valid, input mean_re, input mean_im, input freq_index,
                  input last_freq, input saturated, output ready);
endinterface

@@ rtl/wwks_accum.sv @@
// Wedge position counters, symmetry weighting and row accumulation.
module wwks_accum #(
  parameter int MAX_SIDE    = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wwks_pkg::wwks_cfg_t           cfg,
  input  logic                          adv,
  input  logic                          take,
  input  logic signed [SAMPLE_BITS-1:0] sample_re,
  input  logic signed [SAMPLE_BITS-1:0] sample_im,
  output wwks_pkg::wwks_row_t           row
);

  localparam int ACC_W  = wwks_pkg::ACC_W;
  localparam int FREQ_W = wwks_pkg::FREQ_W;
  localparam int FC_W   = wwks_pkg::FCOUNT_W;
  localparam int POS_W  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > wwks_pkg::SIDE_REG_W) ? SIDE_W : wwks_pkg::SIDE_REG_W;
  localparam logic [CMP_W-1:0] SIDE_MAX = CMP_W'(MAX_SIDE);

  logic [POS_W-1:0]  row_pos;
  logic [POS_W-1:0]  col_pos;
  logic [ACC_W-1:0]  acc_re;
  logic [ACC_W-1:0]  acc_im;
  logic [FREQ_W-1:0] freq_pos;

  logic [CMP_W-1:0]  side_raw;
  logic [CMP_W-1:0]  side;
  logic [CMP_W-1:0]  side_m1;
  logic [FC_W-1:0]   nfreq;
  logic [FC_W-1:0]   freq_inc;
  logic              last_row;
  logic              diag;
  logic              row_end;
  logic              last;
  logic [1:0]        shamt;
  logic [ACC_W-1:0]  ext_re;
  logic [ACC_W-1:0]  ext_im;
  logic [ACC_W-1:0]  acc_re_next;
  logic [ACC_W-1:0]  acc_im_next;

  always_comb begin
    side_raw = CMP_W'(cfg.grid_side);
    if (side_raw == '0) begin
      side = CMP_W'(1);
    end else if (side_raw > SIDE_MAX) begin
      side = SIDE_MAX;
    end else begin
      side = side_raw;
    end
    side_m1 = side - CMP_W'(1);

    if (cfg.freq_count == '0) begin
      nfreq = FC_W'(1);
    end else if (cfg.freq_count > wwks_pkg::FREQ_COUNT_MAX) begin
      nfreq = wwks_pkg::FREQ_COUNT_MAX;
    end else begin
      nfreq = cfg.freq_count;
    end

    last_row = CMP_W'(row_pos) >= side_m1;
    diag     = col_pos >= row_pos;
    row_end  = diag && last_row;
    freq_inc = {1'b0, freq_pos} + FC_W'(1);
    last     = freq_inc >= nfreq;

    // Weights in quarters: 1 at the origin, 2 on the far corner, 4 on the
    // diagonal and along the last row away from column zero, 8 elsewhere.
    if (row_pos == '0 && col_pos == '0) begin
      shamt = 2'd0;
    end else if (diag) begin
      shamt = last_row ? 2'd1 : 2'd2;
    end else if (last_row && col_pos != '0) begin
      shamt = 2'd2;
    end else begin
      shamt = 2'd3;
    end

    ext_re      = {{(ACC_W-SAMPLE_BITS){sample_re[SAMPLE_BITS-1]}}, sample_re};
    ext_im      = {{(ACC_W-SAMPLE_BITS){sample_im[SAMPLE_BITS-1]}}, sample_im};
    acc_re_next = acc_re + (ext_re << shamt);
    acc_im_next = acc_im + (ext_im << shamt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos  <= '0;
      col_pos  <= '0;
      acc_re   <= '0;
      acc_im   <= '0;
      freq_pos <= '0;
    end else if (take) begin
      if (!diag) begin
        col_pos <= col_pos + POS_W'(1);
        acc_re  <= acc_re_next;
        acc_im  <= acc_im_next;
      end else if (!last_row) begin
        col_pos <= '0;
        row_pos <= row_pos + POS_W'(1);
        acc_re  <= acc_re_next;
        acc_im  <= acc_im_next;
      end else begin
        col_pos  <= '0;
        row_pos  <= '0;
        acc_re   <= '0;
        acc_im   <= '0;
        freq_pos <= last ? '0 : freq_inc[FREQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row.valid <= 1'b0;
    end else if (adv) begin
      row.valid <= take && row_end;
    end
    if (adv) begin
      row.sum_re     <= acc_re_next;
      row.sum_im     <= acc_im_next;
      row.freq_index <= freq_pos;
      row.last       <= last;
    end
  end

endmodule

@@ rtl/wwks_scale.sv @@
// Normalising pipeline: magnitude, split multiply, rounding and saturation.
module wwks_scale #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic [wwks_pkg::RECIP_W-1:0]       recip,
  input  wwks_pkg::wwks_row_t                row,
  output logic                               out_valid,
  output logic signed [SAMPLE_BITS-1:0]      mean_re,
  output logic signed [SAMPLE_BITS-1:0]      mean_im,
  output logic [wwks_pkg::FREQ_W-1:0]        freq_index,
  output logic                               last_freq,
  output logic                               saturated
);

  localparam int ACC_W  = wwks_pkg::ACC_W;
  localparam int FREQ_W = wwks_pkg::FREQ_W;
  localparam int R_W    = wwks_pkg::RECIP_W;
  localparam int HI_W   = ACC_W - 32;
  localparam int PL_W   = 32 + R_W;
  localparam int PH_W   = HI_W + R_W;
  localparam int T_W    = PH_W + 1;
  localparam int Q_W    = T_W - 2;
  localparam logic [Q_W-1:0] POS_LIM = {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_LIM = POS_LIM + Q_W'(1);

  typedef struct packed {
    logic              valid;
    logic              neg_re;
    logic              neg_im;
    logic [ACC_W-1:0]  mag_re;
    logic [ACC_W-1:0]  mag_im;
    logic [FREQ_W-1:0] freq_index;
    logic              last;
  } mag_stage_t;

  typedef struct packed {
    logic              valid;
    logic              neg_re;
    logic              neg_im;
    logic [PL_W-1:0]   plo_re;
    logic [PH_W-1:0]   phi_re;
    logic [PL_W-1:0]   plo_im;
    logic [PH_W-1:0]   phi_im;
    logic [FREQ_W-1:0] freq_index;
    logic              last;
  } prod_stage_t;

  mag_stage_t  ms;
  prod_stage_t ps;

  logic [SAMPLE_BITS-1:0] res_re;
  logic [SAMPLE_BITS-1:0] res_im;
  logic                   sat_re;
  logic                   sat_im;

  // Rounds to nearest with ties away from zero, then clips to the sample range.
  function automatic logic [SAMPLE_BITS:0] finish(input logic [PL_W-1:0] plo,
                                                  input logic [PH_W-1:0] phi,
                                                  input logic            neg);
    logic [T_W-1:0] t;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] v;
    logic           sat;
    t   = T_W'(plo[PL_W-1:32]) + T_W'(phi) + T_W'(2);
    q   = t[T_W-1:2];
    sat = 1'b0;
    if (neg) begin
      if (q > NEG_LIM) begin
        q   = NEG_LIM;
        sat = 1'b1;
      end
      v = '0 - q;
    end else begin
      if (q > POS_LIM) begin
        q   = POS_LIM;
        sat = 1'b1;
      end
      v = q;
    end
    return {sat, v[SAMPLE_BITS-1:0]};
  endfunction

  always_comb begin
    {sat_re, res_re} = finish(ps.plo_re, ps.phi_re, ps.neg_re);
    {sat_im, res_im} = finish(ps.plo_im, ps.phi_im, ps.neg_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms.valid  <= 1'b0;
      ps.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      ms.valid  <= row.valid;
      ps.valid  <= ms.valid;
      out_valid <= ps.valid;
    end
    if (adv) begin
      ms.neg_re     <= row.sum_re[ACC_W-1];
      ms.neg_im     <= row.sum_im[ACC_W-1];
      ms.mag_re     <= row.sum_re[ACC_W-1] ? ('0 - row.sum_re) : row.sum_re;
      ms.mag_im     <= row.sum_im[ACC_W-1] ? ('0 - row.sum_im) : row.sum_im;
      ms.freq_index <= row.freq_index;
      ms.last       <= row.last;

      ps.neg_re     <= ms.neg_re;
      ps.neg_im     <= ms.neg_im;
      ps.plo_re     <= PL_W'(ms.mag_re[31:0]) * PL_W'(recip);
      ps.phi_re     <= PH_W'(ms.mag_re[ACC_W-1:32]) * PH_W'(recip);
      ps.plo_im     <= PL_W'(ms.mag_im[31:0]) * PL_W'(recip);
      ps.phi_im     <= PH_W'(ms.mag_im[ACC_W-1:32]) * PH_W'(recip);
      ps.freq_index <= ms.freq_index;
      ps.last       <= ms.last;

      mean_re    <= res_re;
      mean_im    <= res_im;
      freq_index <= ps.freq_index;
      last_freq  <= ps.last;
      saturated  <= sat_re || sat_im;
    end
  end

endmodule

@@ rtl/wedge_weighted_kpoint_sum.sv @@
// Top level of the wedge weighted k-point sum block.
// After its final sample is taken, a row's sum passes the row register, the magnitude
// stage and the product stage, and its mean is then offered from the output register.
// Throughput: one sample transaction per cycle; the whole pipeline advances together,
// held only while the output register is full and not being taken.
// Reset (synchronous, active high) returns the wedge position, sums and frequency
// row to zero, empties the pipeline and restores the configuration defaults.
module wedge_weighted_kpoint_sum #(
  parameter int MAX_SIDE    = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [wwks_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wwks_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
  wwks_in_if.sink                              sample_in,
  wwks_out_if.source                           mean_out
);

  wwks_pkg::wwks_cfg_t cfg;
  wwks_pkg::wwks_row_t row;
  logic                adv;
  logic                take;

  assign adv             = !mean_out.valid || mean_out.ready;
  assign take            = sample_in.valid && adv;
  assign sample_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_side       <= wwks_pkg::GRID_SIDE_RST;
      cfg.norm_reciprocal <= wwks_pkg::NORM_RECIPROCAL_RST;
      cfg.freq_count      <= wwks_pkg::FREQ_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wwks_pkg::REG_GRID_SIDE: begin
          cfg.grid_side <= cfg_wr_data[wwks_pkg::SIDE_REG_W-1:0];
        end
        wwks_pkg::REG_NORM_RECIPROCAL: begin
          cfg.norm_reciprocal <= cfg_wr_data[wwks_pkg::RECIP_W-1:0];
        end
        wwks_pkg::REG_FREQ_COUNT: begin
          cfg.freq_count <= cfg_wr_data[wwks_pkg::FCOUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  wwks_accum #(
    .MAX_SIDE   (MAX_SIDE),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .adv      (adv),
    .take     (take),
    .sample_re(sample_in.sample_re),
    .sample_im(sample_in.sample_im),
    .row      (row)
  );

  wwks_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .recip     (cfg.norm_reciprocal),
    .row       (row),
    .out_valid (mean_out.valid),
    .mean_re   (mean_out.mean_re),
    .mean_im   (mean_out.mean_im),
    .freq_index(mean_out.freq_index),
    .last_freq (mean_out.last_freq),
    .saturated (mean_out.saturated)
  );

endmodule

@@ rtl/wwks_checker.sv @@
// Port-level checks for the wedge weighted k-point sum block, with its bind.
module wwks_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] mean_re,
  input logic signed [SAMPLE_BITS-1:0] mean_im,
  input logic [wwks_pkg::FREQ_W-1:0]   freq_index,
  input logic                          last_freq,
  input logic                          saturated
);

  localparam logic [SAMPLE_BITS-1:0] MAX_V = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MIN_V = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // A waiting result stays offered until its transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transaction completed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  // With the output register empty nothing may hold back new samples.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  // The highest frequency row index is always the final one of a run.
  a_top_row_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (freq_index == '1) |-> last_freq)
    else $error("top frequency row not marked as last");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (mean_re == MAX_V) || (mean_re == MIN_V) ||
                               (mean_im == MAX_V) || (mean_im == MIN_V))
    else $error("saturation flagged without a clipped part");

endmodule

bind wedge_weighted_kpoint_sum wwks_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_wwks_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample_in.ready),
  .out_valid (mean_out.valid),
  .out_ready (mean_out.ready),
  .mean_re   (mean_out.mean_re),
  .mean_im   (mean_out.mean_im),
  .freq_index(mean_out.freq_index),
  .last_freq (mean_out.last_freq),
  .saturated (mean_out.saturated)
);

@@ tb/wwks_mean_checker.sv @@
// Checker that predicts the row means from observed transactions and compares the block's results.
module wwks_mean_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [wwks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wwks_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  wwks_in_if                              sample_ch,
  wwks_out_if                             mean_ch,
  output int                              fail_count,
  output int                              means_waiting,
  output int                              means_checked
);

  localparam int ACC_W      = wwks_pkg::ACC_W;
  localparam int RECIP_W    = wwks_pkg::RECIP_W;
  localparam int FREQ_W     = wwks_pkg::FREQ_W;
  localparam int FCOUNT_W   = wwks_pkg::FCOUNT_W;
  localparam int SIDE_REG_W = wwks_pkg::SIDE_REG_W;
  localparam int SAMPLE_W   = 32;
  localparam int SIDE_MAX   = 256;
  localparam int MUL_W      = ACC_W + RECIP_W;

  localparam logic [MUL_W-1:0] ROUND_HALF = MUL_W'(64'h2_0000_0000);
  localparam logic [MUL_W-1:0] POS_LIMIT  = MUL_W'(64'h7FFF_FFFF);
  localparam logic [MUL_W-1:0] NEG_LIMIT  = MUL_W'(64'h8000_0000);

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean_re;
    logic [SAMPLE_W-1:0] mean_im;
    logic [FREQ_W-1:0]   freq_index;
    logic                last_freq;
    logic                saturated;
  } row_mean_t;

  wwks_pkg::wwks_cfg_t cfg;
  logic [7:0]          row_pos;
  logic [7:0]          col_pos;
  logic [ACC_W-1:0]    sum_re;
  logic [ACC_W-1:0]    sum_im;
  logic [FREQ_W-1:0]   freq_pos;
  row_mean_t           pending_means[$];
  int                  errors;
  int                  checked;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [ACC_W-1:0] add_weighted(input logic [ACC_W-1:0]    sum,
                                                    input logic [SAMPLE_W-1:0] sample,
                                                    input int unsigned         shift);
    logic [ACC_W-1:0] ext;
    ext = {{(ACC_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    return sum + (ext << shift);
  endfunction

  // Returns the clip flag above the 32-bit mean. The magnitude is rounded to nearest with
  // ties away from zero and clipped, and the sign is put back after clipping.
  function automatic logic [SAMPLE_W:0] scale_sum(input logic [ACC_W-1:0]   sum,
                                                  input logic [RECIP_W-1:0] recip);
    logic [MUL_W-1:0] mag;
    logic [MUL_W-1:0] q;
    logic             neg;
    neg = sum[ACC_W-1];
    mag = {{RECIP_W{1'b0}}, (neg ? -sum : sum)};
    q = (mag * {{ACC_W{1'b0}}, recip} + ROUND_HALF) >> 34;
    if (neg) begin
      if (q > NEG_LIMIT) return {1'b1, 32'h8000_0000};
      q = -q;
      return {1'b0, q[SAMPLE_W-1:0]};
    end
    if (q > POS_LIMIT) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, q[SAMPLE_W-1:0]};
  endfunction

  always @(posedge clk) begin : predict_and_check
    logic [9:0]            side;
    logic [FCOUNT_W-1:0]   nfreq;
    logic                  last_row;
    logic                  diag;
    int unsigned           shift;
    logic [SAMPLE_W:0]     scaled_re;
    logic [SAMPLE_W:0]     scaled_im;
    row_mean_t             got;
    row_mean_t             want;
    if (rst) begin
      cfg.grid_side       = wwks_pkg::GRID_SIDE_RST;
      cfg.norm_reciprocal = wwks_pkg::NORM_RECIPROCAL_RST;
      cfg.freq_count      = wwks_pkg::FREQ_COUNT_RST;
      row_pos  = '0;
      col_pos  = '0;
      sum_re   = '0;
      sum_im   = '0;
      freq_pos = '0;
      pending_means.delete();
    end else begin
      // The result taken now always belongs to an earlier sample, so it is checked first.
      if (mean_ch.valid && mean_ch.ready) begin
        got.mean_re    = mean_ch.mean_re;
        got.mean_im    = mean_ch.mean_im;
        got.freq_index = mean_ch.freq_index;
        got.last_freq  = mean_ch.last_freq;
        got.saturated  = mean_ch.saturated;
        if (pending_means.size() == 0) begin
          report_mismatch($sformatf("row mean for row %0d arrived with none pending",
                                    got.freq_index));
        end else begin
          want = pending_means.pop_front();
          checked++;
          if (got.mean_re !== want.mean_re)
            report_mismatch($sformatf("row %0d mean_re: got %h, expected %h",
                                      want.freq_index, got.mean_re, want.mean_re));
          if (got.mean_im !== want.mean_im)
            report_mismatch($sformatf("row %0d mean_im: got %h, expected %h",
                                      want.freq_index, got.mean_im, want.mean_im));
          if (got.freq_index !== want.freq_index)
            report_mismatch($sformatf("freq_index: got %0d, expected %0d",
                                      got.freq_index, want.freq_index));
          if (got.last_freq !== want.last_freq)
            report_mismatch($sformatf("row %0d last_freq: got %b, expected %b",
                                      want.freq_index, got.last_freq, want.last_freq));
          if (got.saturated !== want.saturated)
            report_mismatch($sformatf("row %0d saturated: got %b, expected %b",
                                      want.freq_index, got.saturated, want.saturated));
        end
      end

      if (sample_ch.valid && sample_ch.ready) begin
        side = {1'b0, cfg.grid_side};
        if (side == 10'd0) side = 10'd1;
        if (side > SIDE_MAX) side = 10'(SIDE_MAX);
        nfreq = cfg.freq_count;
        if (nfreq == '0) nfreq = FCOUNT_W'(1);
        if (nfreq > wwks_pkg::FREQ_COUNT_MAX) nfreq = wwks_pkg::FREQ_COUNT_MAX;

        // A row left beyond the last one by a smaller side is treated as the last row.
        last_row = {2'b00, row_pos} >= side - 10'd1;
        diag     = col_pos >= row_pos;

        // Weights in quarters, applied as shifts.
        if (row_pos == '0 && col_pos == '0) shift = 0;
        else if (diag)                      shift = last_row ? 1 : 2;
        else if (last_row && col_pos != '0) shift = 2;
        else                                shift = 3;

        sum_re = add_weighted(sum_re, sample_ch.sample_re, shift);
        sum_im = add_weighted(sum_im, sample_ch.sample_im, shift);

        if (!diag) begin
          col_pos = col_pos + 8'd1;
        end else begin
          col_pos = '0;
          if (!last_row) begin
            row_pos = row_pos + 8'd1;
          end else begin
            row_pos = '0;
            scaled_re = scale_sum(sum_re, cfg.norm_reciprocal);
            scaled_im = scale_sum(sum_im, cfg.norm_reciprocal);
            want.mean_re    = scaled_re[SAMPLE_W-1:0];
            want.mean_im    = scaled_im[SAMPLE_W-1:0];
            want.saturated  = scaled_re[SAMPLE_W] | scaled_im[SAMPLE_W];
            want.freq_index = freq_pos;
            want.last_freq  = ({1'b0, freq_pos} + FCOUNT_W'(1)) >= nfreq;
            pending_means   = {pending_means, want};
            sum_re   = '0;
            sum_im   = '0;
            freq_pos = want.last_freq ? '0 : freq_pos + FREQ_W'(1);
          end
        end
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          wwks_pkg::REG_GRID_SIDE:       cfg.grid_side       = cfg_wr_data[SIDE_REG_W-1:0];
          wwks_pkg::REG_NORM_RECIPROCAL: cfg.norm_reciprocal = cfg_wr_data[RECIP_W-1:0];
          wwks_pkg::REG_FREQ_COUNT:      cfg.freq_count      = cfg_wr_data[FCOUNT_W-1:0];
          default: ;
        endcase
      end
    end
    means_waiting <= pending_means.size();
    means_checked <= checked;
  end

endmodule

@@ tb/tb_wedge_weighted_kpoint_sum.sv @@
// Testbench top for the wedge weighted k-point sum block: stimulus, flow control and verdict.
module tb_wedge_weighted_kpoint_sum;

  localparam int CLK_HALF       = 4;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en;
  logic [wwks_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wwks_pkg::CFG_DATA_W-1:0] cfg_wr_data;

  int   fail_count;
  int   means_waiting;
  int   means_checked;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   samples_sent;
  int   reg_writes;
  logic hold_off = 1'b0;
  event hold_start;

  wwks_in_if  #(.SAMPLE_BITS(32)) sample_ch ();
  wwks_out_if #(.SAMPLE_BITS(32)) mean_ch ();

  wedge_weighted_kpoint_sum u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .sample_in  (sample_ch),
    .mean_out   (mean_ch)
  );

  wwks_mean_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .sample_ch    (sample_ch),
    .mean_ch      (mean_ch),
    .fail_count   (fail_count),
    .means_waiting(means_waiting),
    .means_checked(means_checked)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    mean_ch.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
  end

  // Long receiver hold-off, so that the pipeline fills and back-pressures the input.
  always begin
    @(hold_start);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(512)) - 32'd256;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [wwks_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [wwks_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_config(input logic [wwks_pkg::CFG_DATA_W-1:0] side,
                            input logic [wwks_pkg::CFG_DATA_W-1:0] recip,
                            input logic [wwks_pkg::CFG_DATA_W-1:0] nfreq);
    write_reg(wwks_pkg::REG_GRID_SIDE, side);
    write_reg(wwks_pkg::REG_NORM_RECIPROCAL, recip);
    write_reg(wwks_pkg::REG_FREQ_COUNT, nfreq);
  endtask

  // Expects to be called right after a rising clock; returns once the sample transaction is taken.
  task automatic send_sample(input logic [31:0] re, input logic [31:0] im);
    if ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.sample_re <= re;
    sample_ch.sample_im <= im;
    do @(posedge clk); while (!sample_ch.ready);
    samples_sent++;
  endtask

  // Stops sending and waits for every pending row mean, then lets a part-filled row settle.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (means_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [8:0]  side_pick;
    logic [16:0] nfreq_pick;
    logic [31:0] recip_pick;
    cfg_wr_en           = 1'b0;
    cfg_index           = wwks_pkg::REG_GRID_SIDE;
    cfg_wr_data         = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.sample_re = '0;
    sample_ch.sample_im = '0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    samples_sent        = 0;
    reg_writes          = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Side 2 and two rows, with junk above the register widths. The first row takes extremes
    // in both parts unclipped; the second lands exactly on a half and must round away from zero.
    set_config(32'hFFFF_FE02, 32'h4000_0000, 32'hFFFE_0002);
    repeat (3) send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h0000_0008, 32'hFFFF_FFF8);
    send_sample('0, '0);
    send_sample('0, '0);

    // Side and frequency count of zero both act as one: every sample is a row of its own.
    drain();
    set_config('0, 32'hFFFF_FFFF, '0);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001);

    // Side shrunk in the middle of a row: the row in progress becomes the last one.
    drain();
    set_config(32'd5, '0, 32'h0001_FFFF);
    repeat (8) send_sample(rand_sample(), rand_sample());
    drain();
    write_reg(wwks_pkg::REG_GRID_SIDE, 32'd2);
    write_reg(wwks_pkg::REG_NORM_RECIPROCAL, 32'h0800_0000);
    repeat (2) send_sample(rand_sample(), '0);

    // Frequency count lowered below the current row: the next row ends the run.
    drain();
    write_reg(wwks_pkg::REG_FREQ_COUNT, 32'd1);
    repeat (3) send_sample(32'($urandom_range(512)) - 32'd256, '0);

    // Receiver holds off while the sender keeps going, one row mean per sample.
    drain();
    set_config(32'd1, $urandom, 32'd3);
    -> hold_start;
    repeat (50) send_sample(rand_sample(), rand_sample());

    // Random settings under each idling mix; mostly small sides so rows complete often.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 66; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 66; end
        default: begin src_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      for (int setting = 0; setting < 4; setting++) begin
        drain();
        case ($urandom_range(9))
          0:       side_pick = 9'd0;
          1:       side_pick = 9'd1;
          9:       side_pick = 9'($urandom_range(12, 7));
          default: side_pick = 9'($urandom_range(6, 2));
        endcase
        case ($urandom_range(5))
          0:       nfreq_pick = '0;
          1:       nfreq_pick = $urandom_range(1) ? 17'h1_FFFF : wwks_pkg::FREQ_COUNT_MAX;
          default: nfreq_pick = 17'($urandom_range(4, 1));
        endcase
        case ($urandom_range(5))
          0:       recip_pick = '0;
          1:       recip_pick = 32'hFFFF_FFFF;
          2:       recip_pick = $urandom;
          default: recip_pick = (side_pick <= 9'd1) ? 32'hFFFF_FFFF :
                                32'((64'd1 << 32) / (64'(side_pick) * 64'(side_pick)));
        endcase
        set_config(32'(side_pick), recip_pick, 32'(nfreq_pick));
        for (int i = 0; i < 74; i++) begin
          if (setting == 2 && i == 37) drain();
          send_sample(rand_sample(), ($urandom_range(3) == 0) ? 32'd0 : rand_sample());
        end
      end
    end

    // The largest side, clamped from the all-ones register value: the opening rows of it.
    drain();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_config(32'h0000_01FF, 32'h0001_0000, 32'd1);
    repeat (40) send_sample(rand_sample(), rand_sample());

    drain();
    $display("Checked %0d row means from %0d sample transactions and %0d register writes.",
             means_checked, samples_sent, reg_writes);
    $display("Sides 0 to 12 and the clamped maximum, row counts 0 to 131071, idle mixes, %s",
             "hold-off and mid-row changes.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
